>>> hw/rtl/twpq_pkg.sv
// Shared types, constants and helpers of the timed wake-up priority queue.
`timescale 1ns / 1ps

package twpq_pkg;

	localparam int TIME_BITS  = 48;
	localparam int TAG_BITS   = 16;
	localparam int ORDER_BITS = 32;
	localparam int OCC_BITS   = 6;
	localparam int DEPTH_DEF  = 32;

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_POP   = 2'd1,
		FUNC_SHIFT = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	// Status codes of a result item.
	typedef enum logic [2:0] {
		ST_PUSHED  = 3'd0,
		ST_IGNORED = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_DUE     = 3'd3,
		ST_NONE    = 3'd4,
		ST_SHIFTED = 3'd5,
		ST_CLEARED = 3'd6
	} status_t;

	typedef struct packed {
		func_t                        func;
		logic [TIME_BITS-1:0]         wake_time;
		logic [TIME_BITS-1:0]         now_time;
		logic signed [TIME_BITS-1:0]  shift_delta;
		logic [TAG_BITS-1:0]          entry_tag;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [TAG_BITS-1:0]   due_tag;
		logic                  last_of_run;
		logic [OCC_BITS-1:0]   occupancy;
		logic                  next_valid;
		logic [TIME_BITS-1:0]  next_wake;
	} rsp_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		DP_NOP,
		DP_PUSH,
		DP_LOAD_NOW,
		DP_SHIFT,
		DP_SORT,
		DP_CLEAR,
		DP_POP,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t status;
		logic    last;
		logic    odd;
	} dp_cmd_t;

	typedef struct packed {
		logic tag_zero;
		logic full;
		logic head_due;
		logic next_due;
	} dp_stat_t;

	// True when key (ta, oa) sorts strictly after key (tb, ob).
	function automatic logic key_after(input logic [TIME_BITS-1:0] ta,
			input logic [ORDER_BITS-1:0] oa, input logic [TIME_BITS-1:0] tb,
			input logic [ORDER_BITS-1:0] ob);
		if (ta != tb) begin
			return ta > tb;
		end
		return oa > ob;
	endfunction

endpackage

>>> hw/rtl/timed_wakeup_priority_queue.sv
// Top level of the timed wake-up priority queue.
`timescale 1ns / 1ps
// Usage:
// An item is taken on req at a rising edge where start is high and busy is low.
// Results appear on rsp for exactly one cycle, marked by rsp_valid; the receiver
// cannot hold them off. The item with last_of_run set is the final one of an input.
// Sequence of work over the sorted slot row, set by the sequencer:
//   push, clear: row updated at the accepting edge, then S_FIN loads the result.
//   pop: now time loaded at the accepting edge, then one released entry per cycle
//        in S_POP, or a none result if the head is not due; busy until the last.
//   shift: the delta is applied at the accepting edge, then DEPTH odd-even sort
//          passes, then S_FIN loads the result.
// Reset empties the queue and clears the sequence counter; no clearing pass is
// needed since only slots below the occupancy are read. rsp_valid is low out of
// reset and busy is low, so an item may be started right away.
module timed_wakeup_priority_queue import twpq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output rsp_t rsp,
	output logic rsp_valid
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	twpq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (req.func),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Slot row and result register.
	twpq_dp #(.DEPTH(DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

endmodule

>>> hw/rtl/twpq_ctrl.sv
// Controller state machine of the timed wake-up priority queue.
`timescale 1ns / 1ps

module twpq_ctrl import twpq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  func_t    func,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  cmd
);

	localparam int PW = $clog2(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SORT,
		S_FIN
	} state_t;

	state_t          state_q;
	status_t         status_q;
	logic [PW-1:0]   pass_q;

	assign busy = (state_q != S_IDLE);

	// Command decode for the datapath.
	always_comb begin
		cmd = '{op: DP_NOP, status: ST_PUSHED, last: 1'b1, odd: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (func)
						FUNC_PUSH:  cmd.op = (stat.tag_zero || stat.full) ? DP_NOP : DP_PUSH;
						FUNC_POP:   cmd.op = DP_LOAD_NOW;
						FUNC_SHIFT: cmd.op = DP_SHIFT;
						FUNC_CLEAR: cmd.op = DP_CLEAR;
					endcase
				end
			end
			S_POP: begin
				if (stat.head_due) begin
					cmd.op     = DP_POP;
					cmd.status = ST_DUE;
					cmd.last   = !stat.next_due;
				end else begin
					cmd.op     = DP_EMIT;
					cmd.status = ST_NONE;
				end
			end
			S_SORT: begin
				cmd.op  = DP_SORT;
				cmd.odd = pass_q[0];
			end
			S_FIN: begin
				cmd.op     = DP_EMIT;
				cmd.status = status_q;
			end
		endcase
	end

	// State, held status and sort pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_PUSHED;
			pass_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (func)
							FUNC_PUSH: begin
								state_q <= S_FIN;
								if (stat.tag_zero) begin
									status_q <= ST_IGNORED;
								end else if (stat.full) begin
									status_q <= ST_OVERFLOW;
								end else begin
									status_q <= ST_PUSHED;
								end
							end
							FUNC_POP: state_q <= S_POP;
							FUNC_SHIFT: begin
								state_q  <= S_SORT;
								status_q <= ST_SHIFTED;
								pass_q   <= '0;
							end
							FUNC_CLEAR: begin
								state_q  <= S_FIN;
								status_q <= ST_CLEARED;
							end
						endcase
					end
				end
				S_POP: begin
					if (!stat.head_due || !stat.next_due) begin
						state_q <= S_IDLE;
					end
				end
				S_SORT: begin
					pass_q <= pass_q + 1'b1;
					if (pass_q == PW'(DEPTH - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/twpq_dp.sv
// Datapath of the timed wake-up priority queue: sorted slot row and result register.
`timescale 1ns / 1ps

module twpq_dp import twpq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output rsp_t     rsp,
	output logic     rsp_valid
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [TIME_BITS-1:0]  time_q [DEPTH];
	logic [ORDER_BITS-1:0] ord_q  [DEPTH];
	logic [TAG_BITS-1:0]   tag_q  [DEPTH];
	logic [TIME_BITS-1:0]  time_d [DEPTH];
	logic [ORDER_BITS-1:0] ord_d  [DEPTH];
	logic [TAG_BITS-1:0]   tag_d  [DEPTH];
	logic [CW-1:0]         count_q, count_d;
	logic [ORDER_BITS-1:0] order_q, order_d;
	logic [TIME_BITS-1:0]  now_q;
	logic [DEPTH-1:0]      after_new;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	// Saturating add of a signed delta to one wake time.
	function automatic logic [TIME_BITS-1:0] shift_time(input logic [TIME_BITS-1:0] t,
			input logic signed [TIME_BITS-1:0] d);
		logic signed [TIME_BITS+1:0] sum;
		sum = $signed({2'b00, t}) + $signed({{2{d[TIME_BITS-1]}}, d});
		if (sum[TIME_BITS+1]) begin
			return '0;
		end else if (sum[TIME_BITS]) begin
			return '1;
		end
		return sum[TIME_BITS-1:0];
	endfunction

	// A slot sorts after the new entry; empty slots count as after.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			after_new[i] = (CW'(i) < count_q) ?
				key_after(time_q[i], ord_q[i], req.wake_time, order_q) : 1'b1;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.tag_zero = (req.entry_tag == '0);
		stat.full     = (count_q == CW'(DEPTH));
		stat.head_due = (count_q != '0) && (time_q[0] <= now_q);
		stat.next_due = (count_q > CW'(1)) && (time_q[1] <= now_q);
	end

	// Next contents of the slot row.
	always_comb begin
		time_d  = time_q;
		ord_d   = ord_q;
		tag_d   = tag_q;
		count_d = count_q;
		order_d = order_q;
		unique case (cmd.op)
			DP_PUSH: begin
				if (after_new[0]) begin
					time_d[0] = req.wake_time;
					ord_d[0]  = order_q;
					tag_d[0]  = req.entry_tag;
				end
				for (int i = 1; i < DEPTH; i++) begin
					if (after_new[i] && !after_new[i-1]) begin
						time_d[i] = req.wake_time;
						ord_d[i]  = order_q;
						tag_d[i]  = req.entry_tag;
					end else if (after_new[i]) begin
						time_d[i] = time_q[i-1];
						ord_d[i]  = ord_q[i-1];
						tag_d[i]  = tag_q[i-1];
					end
				end
				count_d = count_q + 1'b1;
				order_d = order_q + 1'b1;
			end
			DP_POP: begin
				for (int i = 0; i < DEPTH - 1; i++) begin
					time_d[i] = time_q[i+1];
					ord_d[i]  = ord_q[i+1];
					tag_d[i]  = tag_q[i+1];
				end
				count_d = count_q - 1'b1;
			end
			DP_SHIFT: begin
				for (int i = 0; i < DEPTH; i++) begin
					time_d[i] = shift_time(time_q[i], req.shift_delta);
				end
			end
			DP_SORT: begin
				// One odd-even transposition pass; strict compare keeps it stable.
				for (int i = 0; i < DEPTH - 1; i++) begin
					if (((i % 2) == int'(cmd.odd)) && (CW'(i + 1) < count_q) &&
							key_after(time_q[i], ord_q[i], time_q[i+1], ord_q[i+1])) begin
						time_d[i]   = time_q[i+1];
						ord_d[i]    = ord_q[i+1];
						tag_d[i]    = tag_q[i+1];
						time_d[i+1] = time_q[i];
						ord_d[i+1]  = ord_q[i];
						tag_d[i+1]  = tag_q[i];
					end
				end
			end
			DP_CLEAR: count_d = '0;
			default: ;
		endcase
	end

	// Slot row payload.
	always_ff @(posedge clk) begin
		time_q <= time_d;
		ord_q  <= ord_d;
		tag_q  <= tag_d;
		if (cmd.op == DP_LOAD_NOW) begin
			now_q <= req.now_time;
		end
	end

	// Occupancy, sequence counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			order_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			order_q     <= order_d;
			rsp_valid_q <= (cmd.op == DP_POP) || (cmd.op == DP_EMIT);
		end
	end

	// Result register, loaded with the state after the item's effect.
	always_ff @(posedge clk) begin
		if (cmd.op == DP_POP) begin
			rsp_q.status      <= cmd.status;
			rsp_q.due_tag     <= tag_q[0];
			rsp_q.last_of_run <= cmd.last;
			rsp_q.occupancy   <= OCC_BITS'(count_q - 1'b1);
			rsp_q.next_valid  <= (count_q > CW'(1));
			rsp_q.next_wake   <= (count_q > CW'(1)) ? time_q[1] : '0;
		end else if (cmd.op == DP_EMIT) begin
			rsp_q.status      <= cmd.status;
			rsp_q.due_tag     <= '0;
			rsp_q.last_of_run <= cmd.last;
			rsp_q.occupancy   <= OCC_BITS'(count_q);
			rsp_q.next_valid  <= (count_q != '0);
			rsp_q.next_wake   <= (count_q != '0) ? time_q[0] : '0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

>>> hw/rtl/twpq_chk.sv
// Port-level checker of the timed wake-up priority queue and its bind.
`timescale 1ns / 1ps

module twpq_chk import twpq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input rsp_t rsp,
	input logic rsp_valid
);

	// An accepted item always raises busy in the cycle after it is taken.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	// Results only follow cycles in which an item was being worked on.
	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(busy)) else $error("result without work in progress");

	// Only released entries can be followed by further results of the run.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DUE) |-> rsp.last_of_run)
		else $error("non-release result not marked last");

	// A tag is reported only with a released entry.
	a_tag_only_due: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DUE) |-> (rsp.due_tag == '0))
		else $error("tag reported without release");

	// An empty queue reports a zero wake time.
	a_empty_wake: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.next_valid |-> (rsp.next_wake == '0))
		else $error("empty queue with nonzero wake time");

endmodule

bind timed_wakeup_priority_queue twpq_chk u_chk (.*);
